// File: rtl/core/nrsh_pkg.sv
// nrsh_pkg: types, constants and codes shared by the nearest ray-segment hit block.
// No dependencies; every other file in rtl/core uses it through scoped names.
`timescale 1ns / 1ps

package nrsh_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int NUM_W     = PROD_W + 1;
   localparam int TQ_W      = FRAC_BITS + 1;
   localparam int CNT_W     = $clog2(FRAC_BITS);
   localparam int COUNT_W   = 16;
   localparam int CAP_W     = 31;
   localparam int DIST_W    = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CAP_W-1:0]  CAP_RESET    = CAP_W'(100 << FRAC_BITS);
   localparam logic [DIST_W-1:0] CAP_SQ_RESET = DIST_W'(CAP_RESET) * DIST_W'(CAP_RESET);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X     = 3'd0,
      CSR_ORIGIN_Y     = 3'd1,
      CSR_RAY_END_X    = 3'd2,
      CSR_RAY_END_Y    = 3'd3,
      CSR_DISTANCE_CAP = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DEN,
      ST_MUL_SN,
      ST_MUL_TN,
      ST_TEST,
      ST_DIV,
      ST_SCALE,
      ST_SQUARE,
      ST_COMPARE,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] seg_start_x;
      logic signed [COORD_W-1:0] seg_start_y;
      logic signed [COORD_W-1:0] seg_end_x;
      logic signed [COORD_W-1:0] seg_end_y;
      logic                      last_segment;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]        hit_count;
      logic                      hit_found;
      logic signed [COORD_W-1:0] nearest_x;
      logic signed [COORD_W-1:0] nearest_y;
   } rsp_type;

   // One classified wall, ready for the arithmetic back end.
   typedef struct packed {
      logic signed [DIFF_W-1:0] s1x;
      logic signed [DIFF_W-1:0] s1y;
      logic signed [DIFF_W-1:0] s2x;
      logic signed [DIFF_W-1:0] s2y;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic                     last;
   } work_type;

   // Configuration seen by the back end.
   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic                      cap_write;
      logic [CAP_W-1:0]          cap_value;
   } cfg_type;

endpackage

// File: rtl/core/nrsh_queue.sv
// nrsh_queue: two-entry queue of work words between front and back end.
// Depends on nrsh_pkg for the work word type.
`timescale 1ns / 1ps

module nrsh_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nrsh_pkg::work_type  push_data,
   input  logic                pop,
   output nrsh_pkg::work_type  pop_data,
   output logic                full,
   output logic                empty
);

   nrsh_pkg::work_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/nrsh_front.sv
// nrsh_front: configuration registers and input stage; forms ray and wall deltas.
// Depends on nrsh_pkg for payload, work word and register codes.
`timescale 1ns / 1ps

module nrsh_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  nrsh_pkg::req_type                  req_data,
   input  logic                               csr_write,
   input  logic [nrsh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nrsh_pkg::COORD_W-1:0]       csr_data,
   input  logic                               queue_full,
   output logic                               push,
   output nrsh_pkg::work_type                 push_data,
   output nrsh_pkg::cfg_type                  cfg
);

   logic signed [nrsh_pkg::COORD_W-1:0] origin_x_ff, origin_y_ff;
   logic signed [nrsh_pkg::COORD_W-1:0] ray_end_x_ff, ray_end_y_ff;
   logic [nrsh_pkg::CAP_W-1:0]          cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         ray_end_x_ff <= '0;
         ray_end_y_ff <= '0;
         cap_ff       <= nrsh_pkg::CAP_RESET;
      end else if (csr_write) begin
         case (nrsh_pkg::csr_index_type'(csr_index))
            nrsh_pkg::CSR_ORIGIN_X:     origin_x_ff  <= csr_data;
            nrsh_pkg::CSR_ORIGIN_Y:     origin_y_ff  <= csr_data;
            nrsh_pkg::CSR_RAY_END_X:    ray_end_x_ff <= csr_data;
            nrsh_pkg::CSR_RAY_END_Y:    ray_end_y_ff <= csr_data;
            nrsh_pkg::CSR_DISTANCE_CAP: cap_ff       <= csr_data[nrsh_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.origin_x  = origin_x_ff;
      cfg.origin_y  = origin_y_ff;
      cfg.cap_write = csr_write &&
                      (nrsh_pkg::csr_index_type'(csr_index) == nrsh_pkg::CSR_DISTANCE_CAP);
      cfg.cap_value = csr_data[nrsh_pkg::CAP_W-1:0];
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_data.s1x  = nrsh_pkg::DIFF_W'(ray_end_x_ff) - nrsh_pkg::DIFF_W'(origin_x_ff);
      push_data.s1y  = nrsh_pkg::DIFF_W'(ray_end_y_ff) - nrsh_pkg::DIFF_W'(origin_y_ff);
      push_data.s2x  = nrsh_pkg::DIFF_W'(req_data.seg_end_x) -
                       nrsh_pkg::DIFF_W'(req_data.seg_start_x);
      push_data.s2y  = nrsh_pkg::DIFF_W'(req_data.seg_end_y) -
                       nrsh_pkg::DIFF_W'(req_data.seg_start_y);
      push_data.dx   = nrsh_pkg::DIFF_W'(origin_x_ff) - nrsh_pkg::DIFF_W'(req_data.seg_start_x);
      push_data.dy   = nrsh_pkg::DIFF_W'(origin_y_ff) - nrsh_pkg::DIFF_W'(req_data.seg_start_y);
      push_data.last = req_data.last_segment;
   end

endmodule

// File: rtl/core/nrsh_back.sv
// nrsh_back: sequencer with a shared multiplier pair and a bit-serial divider;
// keeps scene state and drives the result register. Depends on nrsh_pkg.
`timescale 1ns / 1ps

module nrsh_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   output logic                pop,
   input  nrsh_pkg::work_type  pop_data,
   input  nrsh_pkg::cfg_type   cfg,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output nrsh_pkg::rsp_type   rsp_data
);

   localparam int DW = nrsh_pkg::DIFF_W;
   localparam int PW = nrsh_pkg::PROD_W;
   localparam int NW = nrsh_pkg::NUM_W;
   localparam int CW = nrsh_pkg::COORD_W;
   localparam int TW = nrsh_pkg::TQ_W;
   localparam int SW = nrsh_pkg::DIST_W;
   localparam int F  = nrsh_pkg::FRAC_BITS;

   nrsh_pkg::back_state_type state_ff, state_in;
   nrsh_pkg::work_type       work_ff, work_in;

   logic signed [PW-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic signed [DW-1:0] op_a0, op_a1, op_b0, op_b1;
   logic signed [NW-1:0] den_raw_ff, den_raw_in, sn_raw_ff, sn_raw_in;
   logic [NW-1:0]        den_ff, den_in, rem_ff, rem_in;
   logic [TW-1:0]        tq_ff, tq_in;
   logic [nrsh_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [CW-1:0] ix_ff, ix_in, iy_ff, iy_in;

   logic [nrsh_pkg::COUNT_W-1:0] hits_ff, hits_in;
   logic [SW-1:0]        best_ff, best_in, cap_sq_ff, cap_sq_in;
   logic signed [CW-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic                 valid_ff, valid_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   nrsh_pkg::rsp_type    rsp_ff, rsp_in;

   // test and scaling helpers
   logic signed [NW-1:0] tn_raw, den_n, sn_n, tn_n;
   logic                 hit;
   logic [NW:0]          rem2;
   logic signed [PW-1:0] off_x, off_y;
   logic [CW-1:0]        ex, ey;
   logic [SW:0]          sq_sum;
   logic [SW-1:0]        sq;
   logic                 can_load;
   logic [2*nrsh_pkg::CAP_W-1:0] cap_prod;
   logic [SW-1:0]        new_cap_sq;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign cap_prod  = cfg.cap_value * cfg.cap_value;
   assign new_cap_sq = SW'(cap_prod);

   always_comb begin
      tn_raw = NW'(prod_a_ff) - NW'(prod_b_ff);
      if (den_raw_ff < 0) begin
         den_n = -den_raw_ff;
         sn_n  = -sn_raw_ff;
         tn_n  = -tn_raw;
      end else begin
         den_n = den_raw_ff;
         sn_n  = sn_raw_ff;
         tn_n  = tn_raw;
      end
      hit   = (den_raw_ff != 0) && (sn_n >= 0) && (sn_n <= den_n) &&
              (tn_n >= 0) && (tn_n <= den_n);
      rem2  = {rem_ff, 1'b0};
      off_x = prod_a_ff >>> F;
      off_y = prod_b_ff >>> F;
      ex    = off_x[PW-1] ? CW'(-off_x) : CW'(off_x);
      ey    = off_y[PW-1] ? CW'(-off_y) : CW'(off_y);
      sq_sum = {1'b0, prod_a_ff[SW-1:0]} + {1'b0, prod_b_ff[SW-1:0]};
      sq     = sq_sum[SW] ? '1 : sq_sum[SW-1:0];
   end

   // shared multiplier pair: operands chosen by state
   always_comb begin
      case (state_ff)
         nrsh_pkg::ST_MUL_DEN: begin
            op_a0 = work_ff.s1x; op_a1 = work_ff.s2y;
            op_b0 = work_ff.s2x; op_b1 = work_ff.s1y;
         end
         nrsh_pkg::ST_MUL_SN: begin
            op_a0 = work_ff.s1x; op_a1 = work_ff.dy;
            op_b0 = work_ff.s1y; op_b1 = work_ff.dx;
         end
         nrsh_pkg::ST_MUL_TN: begin
            op_a0 = work_ff.s2x; op_a1 = work_ff.dy;
            op_b0 = work_ff.s2y; op_b1 = work_ff.dx;
         end
         nrsh_pkg::ST_SCALE: begin
            op_a0 = DW'(tq_ff); op_a1 = work_ff.s1x;
            op_b0 = DW'(tq_ff); op_b1 = work_ff.s1y;
         end
         nrsh_pkg::ST_SQUARE: begin
            op_a0 = DW'(ex); op_a1 = DW'(ex);
            op_b0 = DW'(ey); op_b1 = DW'(ey);
         end
         default: begin
            op_a0 = '0; op_a1 = '0;
            op_b0 = '0; op_b1 = '0;
         end
      endcase
      prod_a_in = op_a0 * op_a1;
      prod_b_in = op_b0 * op_b1;
   end

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      den_raw_in   = den_raw_ff;
      sn_raw_in    = sn_raw_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      tq_in        = tq_ff;
      cnt_in       = cnt_ff;
      ix_in        = ix_ff;
      iy_in        = iy_ff;
      hits_in      = hits_ff;
      best_in      = best_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      valid_in     = valid_ff;
      cap_sq_in    = cap_sq_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      pop          = 1'b0;

      // cap writes are to come only while idle; the block itself does not enforce this
      if (cfg.cap_write) begin
         cap_sq_in = new_cap_sq;
         if (!valid_ff) begin
            best_in = new_cap_sq;
         end
      end

      case (state_ff)
         nrsh_pkg::ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               work_in  = pop_data;
               state_in = nrsh_pkg::ST_MUL_DEN;
            end
         end
         nrsh_pkg::ST_MUL_DEN: state_in = nrsh_pkg::ST_MUL_SN;
         nrsh_pkg::ST_MUL_SN: begin
            den_raw_in = NW'(prod_a_ff) - NW'(prod_b_ff);
            state_in   = nrsh_pkg::ST_MUL_TN;
         end
         nrsh_pkg::ST_MUL_TN: begin
            sn_raw_in = NW'(prod_a_ff) - NW'(prod_b_ff);
            state_in  = nrsh_pkg::ST_TEST;
         end
         nrsh_pkg::ST_TEST: begin
            if (hit) begin
               if (hits_ff != nrsh_pkg::COUNT_MAX) begin
                  hits_in = hits_ff + 1'b1;
               end
               den_in = den_n;
               rem_in = tn_n;
               cnt_in = '0;
               if (tn_n == den_n) begin
                  tq_in    = TW'(1) << F;
                  state_in = nrsh_pkg::ST_SCALE;
               end else begin
                  tq_in    = '0;
                  state_in = nrsh_pkg::ST_DIV;
               end
            end else begin
               state_in = nrsh_pkg::ST_FINISH;
            end
         end
         nrsh_pkg::ST_DIV: begin
            // one quotient bit per cycle, restoring
            if (rem2 >= {1'b0, den_ff}) begin
               rem_in = NW'(rem2 - {1'b0, den_ff});
               tq_in  = {tq_ff[TW-2:0], 1'b1};
            end else begin
               rem_in = NW'(rem2);
               tq_in  = {tq_ff[TW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == nrsh_pkg::CNT_W'(F - 1)) begin
               state_in = nrsh_pkg::ST_SCALE;
            end
         end
         nrsh_pkg::ST_SCALE: state_in = nrsh_pkg::ST_SQUARE;
         nrsh_pkg::ST_SQUARE: begin
            ix_in    = cfg.origin_x + CW'(off_x);
            iy_in    = cfg.origin_y + CW'(off_y);
            state_in = nrsh_pkg::ST_COMPARE;
         end
         nrsh_pkg::ST_COMPARE: begin
            if (sq < best_ff) begin
               best_in   = sq;
               best_x_in = ix_ff;
               best_y_in = iy_ff;
               valid_in  = 1'b1;
            end
            state_in = nrsh_pkg::ST_FINISH;
         end
         nrsh_pkg::ST_FINISH: begin
            if (!work_ff.last) begin
               state_in = nrsh_pkg::ST_IDLE;
            end else if (can_load) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hit_count   = hits_ff;
               rsp_in.hit_found   = valid_ff;
               rsp_in.nearest_x   = valid_ff ? best_x_ff : '0;
               rsp_in.nearest_y   = valid_ff ? best_y_ff : '0;
               hits_in   = '0;
               best_in   = cap_sq_ff;
               best_x_in = '0;
               best_y_in = '0;
               valid_in  = 1'b0;
               state_in  = nrsh_pkg::ST_IDLE;
            end
         end
         default: state_in = nrsh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nrsh_pkg::ST_IDLE;
         hits_ff      <= '0;
         best_ff      <= nrsh_pkg::CAP_SQ_RESET;
         cap_sq_ff    <= nrsh_pkg::CAP_SQ_RESET;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hits_ff      <= hits_in;
         best_ff      <= best_in;
         cap_sq_ff    <= cap_sq_in;
         best_x_ff    <= best_x_in;
         best_y_ff    <= best_y_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      prod_a_ff  <= prod_a_in;
      prod_b_ff  <= prod_b_in;
      den_raw_ff <= den_raw_in;
      sn_raw_ff  <= sn_raw_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      tq_ff      <= tq_in;
      cnt_ff     <= cnt_in;
      ix_ff      <= ix_in;
      iy_ff      <= iy_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// File: rtl/core/nearest_ray_segment_hit.sv
// nearest_ray_segment_hit: top level; front end, work queue and back end.
// Depends on nrsh_pkg, nrsh_front, nrsh_queue and nrsh_back.
`timescale 1ns / 1ps

// Nearest crossing of a configured ray segment with a stream of wall segments.
// Write origin, ray end and distance cap through the csr_ port (one write per
// cycle, no read-back) while the block is idle. Then send walls on the req_
// channel, one word per wall in signed fixed point; the word with last_segment
// set closes the scene. Only that word yields a rsp_ word: hit count, found
// flag and the nearest kept hit point, after which the scene state clears.
// The front end takes a wall word whenever its two-entry queue has room and
// works out the ray and wall deltas. The back end runs each wall through a
// shared pair of multipliers and a one-bit-per-cycle divider; a wall that
// misses skips the divider, and so does a hit at the ray end. The result
// word is registered from the final step of the last wall. When rsp_stall is
// high the result word holds in its output register; once another scene
// ends, the back end waits in its final step while the queue keeps taking
// walls until full.
// Reset clears the queue, the scene state and the registers (cap 100.0).

module nearest_ray_segment_hit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  nrsh_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output nrsh_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write,
   input  logic [nrsh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nrsh_pkg::COORD_W-1:0]       csr_data
);

   logic               push, pop, queue_full, queue_empty;
   nrsh_pkg::work_type push_data, pop_data;
   nrsh_pkg::cfg_type  cfg;

   // accept walls and keep the configuration
   nrsh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data),
      .cfg        (cfg)
   );

   // decouple front from back
   nrsh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // test, divide, scale and keep the nearest hit
   nrsh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop         (pop),
      .pop_data    (pop_data),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   a_no_point_without_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit_found |-> rsp_data.nearest_x == '0 &&
                                          rsp_data.nearest_y == '0)
      else $error("nearest point set without a kept hit");

   a_found_needs_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_found |-> rsp_data.hit_count != '0)
      else $error("kept hit with zero hit count");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      queue_empty |-> !pop)
      else $error("back end took a word from an empty queue");

endmodule

// File: tb/sv/testbench.sv
// testbench: self-checking bench for nearest_ray_segment_hit, with a directed
// table and random wall scenes checked against an in-bench hit predictor.
// Depends on nrsh_pkg and the nearest_ray_segment_hit RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int FRAC_BITS = nrsh_pkg::FRAC_BITS;
   localparam int COORD_W   = nrsh_pkg::COORD_W;
   localparam int CAP_W     = nrsh_pkg::CAP_W;
   localparam int COUNT_W   = nrsh_pkg::COUNT_W;
   localparam int CSR_IDX_W = nrsh_pkg::CSR_IDX_W;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int SETTLE_CYCLES = 40;      // the longest wall is a hit that runs through the divider
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_WORDS   = 333;
   localparam logic [63:0] DIST_SAT = '1;

   typedef enum {ROW_WALL, ROW_REG} row_kind_type;
   typedef struct {
      row_kind_type         kind;
      nrsh_pkg::req_type    wall;
      logic [CSR_IDX_W-1:0] idx;
      logic [COORD_W-1:0]   value;
      bit                   typed;
      nrsh_pkg::rsp_type    want;
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   nrsh_pkg::req_type req_data;
   nrsh_pkg::rsp_type rsp_data;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0] csr_data;

   // Predictor copy of the registers and the open scene.
   logic signed [COORD_W-1:0] org_x, org_y, ray_ex, ray_ey;
   logic [CAP_W-1:0] cap;
   logic [COUNT_W-1:0] hits;
   logic [63:0] best_sq;
   logic signed [COORD_W-1:0] best_x, best_y;
   bit best_valid;

   nrsh_pkg::rsp_type scene_results_q[$];
   int errors = 0;
   int tx_idle_pct = 0, rx_idle_pct = 0, hold_left = 0;

   nearest_ray_segment_hit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop if the block hangs.
   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [COORD_W-1:0] fx(input int n);
      return COORD_W'(n) << FRAC_BITS;
   endfunction

   function automatic void clear_scene();
      hits = '0;
      best_sq = 64'(cap) * 64'(cap);
      best_x = '0;
      best_y = '0;
      best_valid = 0;
   endfunction

   // Parametric test of one wall against the ray, then scene bookkeeping.
   function automatic void trace_wall(input nrsh_pkg::req_type w, output bit emits,
                                      output nrsh_pkg::rsp_type r);
      logic signed [127:0] s1x, s1y, s2x, s2y, dx, dy, den, sn, tn, tq, ix, iy, mx, my;
      logic [127:0] sq;
      s1x = $signed(ray_ex) - $signed(org_x);
      s1y = $signed(ray_ey) - $signed(org_y);
      s2x = $signed(w.seg_end_x) - $signed(w.seg_start_x);
      s2y = $signed(w.seg_end_y) - $signed(w.seg_start_y);
      dx  = $signed(org_x) - $signed(w.seg_start_x);
      dy  = $signed(org_y) - $signed(w.seg_start_y);
      den = s1x * s2y - s2x * s1y;
      sn  = s1x * dy - s1y * dx;
      tn  = s2x * dy - s2y * dx;
      emits = 0;
      r = '0;
      if (den != 0) begin
         if (den < 0) begin
            den = -den;
            sn = -sn;
            tn = -tn;
         end
         if (sn >= 0 && sn <= den && tn >= 0 && tn <= den) begin
            if (hits != nrsh_pkg::COUNT_MAX) hits++;
            // truncating divide; tn == den gives exactly one
            tq = (tn <<< FRAC_BITS) / den;
            ix = $signed(org_x) + ((tq * s1x) >>> FRAC_BITS);
            iy = $signed(org_y) + ((tq * s1y) >>> FRAC_BITS);
            mx = ix - $signed(org_x);
            my = iy - $signed(org_y);
            if (mx < 0) mx = -mx;
            if (my < 0) my = -my;
            sq = mx * mx + my * my;
            if (sq > {64'b0, DIST_SAT}) sq = {64'b0, DIST_SAT};
            // strict compare: on a tie the earlier hit stays
            if (sq[63:0] < best_sq) begin
               best_sq = sq[63:0];
               best_x = ix[COORD_W-1:0];
               best_y = iy[COORD_W-1:0];
               best_valid = 1;
            end
         end
      end
      if (w.last_segment) begin
         emits = 1;
         r.hit_count = hits;
         r.hit_found = best_valid;
         r.nearest_x = best_valid ? best_x : '0;
         r.nearest_y = best_valid ? best_y : '0;
         clear_scene();
      end
   endfunction

   // Receiver: random stall, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scene_results_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $realtime, rsp_data);
            errors++;
         end else begin
            nrsh_pkg::rsp_type exp_word;
            exp_word = scene_results_q.pop_front();
            if (rsp_data.hit_count !== exp_word.hit_count) begin
               $display("%0t: hit_count expected %h actual %h", $realtime,
                        exp_word.hit_count, rsp_data.hit_count);
               errors++;
            end
            if (rsp_data.hit_found !== exp_word.hit_found) begin
               $display("%0t: hit_found expected %h actual %h", $realtime,
                        exp_word.hit_found, rsp_data.hit_found);
               errors++;
            end
            if (rsp_data.nearest_x !== exp_word.nearest_x) begin
               $display("%0t: nearest_x expected %h actual %h", $realtime,
                        exp_word.nearest_x, rsp_data.nearest_x);
               errors++;
            end
            if (rsp_data.nearest_y !== exp_word.nearest_y) begin
               $display("%0t: nearest_y expected %h actual %h", $realtime,
                        exp_word.nearest_y, rsp_data.nearest_y);
               errors++;
            end
         end
      end
   end

   // Offer one wall word, hold it until taken, then predict.
   task automatic send_wall(input nrsh_pkg::req_type w, input bit typed,
                            input nrsh_pkg::rsp_type want);
      bit emits;
      nrsh_pkg::rsp_type r;
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      trace_wall(w, emits, r);
      if (emits) scene_results_q.push_back(typed ? want : r);
   endtask

   task automatic stop_words();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait for all results, then let a wall that yields none finish too.
   task automatic wait_drained();
      while (scene_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         nrsh_pkg::CSR_ORIGIN_X:  org_x = value;
         nrsh_pkg::CSR_ORIGIN_Y:  org_y = value;
         nrsh_pkg::CSR_RAY_END_X: ray_ex = value;
         nrsh_pkg::CSR_RAY_END_Y: ray_ey = value;
         nrsh_pkg::CSR_DISTANCE_CAP: begin
            cap = value[CAP_W-1:0];
            // a kept hit pins the current bound until the scene ends
            if (!best_valid) best_sq = 64'(cap) * 64'(cap);
         end
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Idle, then load a fresh ray and mostly a cap (else an unmapped write); extremes show up now and then.
   task automatic load_ray();
      int pick;
      stop_words();
      wait_drained();
      pick = $urandom_range(9);
      if (pick == 0) begin
         write_reg(nrsh_pkg::CSR_ORIGIN_X, $urandom);
         write_reg(nrsh_pkg::CSR_ORIGIN_Y, $urandom);
         write_reg(nrsh_pkg::CSR_RAY_END_X, $urandom);
         write_reg(nrsh_pkg::CSR_RAY_END_Y, $urandom);
      end else begin
         write_reg(nrsh_pkg::CSR_ORIGIN_X, $urandom_range(32'h0200_0000) - 32'h0100_0000);
         write_reg(nrsh_pkg::CSR_ORIGIN_Y, $urandom_range(32'h0200_0000) - 32'h0100_0000);
         write_reg(nrsh_pkg::CSR_RAY_END_X, $urandom_range(32'h0200_0000) - 32'h0100_0000);
         write_reg(nrsh_pkg::CSR_RAY_END_Y, $urandom_range(32'h0200_0000) - 32'h0100_0000);
      end
      case ($urandom_range(5))
         0: write_reg(nrsh_pkg::CSR_DISTANCE_CAP, 32'd0);
         1: write_reg(nrsh_pkg::CSR_DISTANCE_CAP, 32'h7FFF_FFFF);
         2: write_reg(nrsh_pkg::CSR_DISTANCE_CAP, COORD_W'(nrsh_pkg::CAP_RESET));
         3: write_reg(CSR_UNMAPPED - CSR_IDX_W'($urandom_range(2)), $urandom);
         default: write_reg(nrsh_pkg::CSR_DISTANCE_CAP, $urandom_range(32'h0100_0000));
      endcase
      end_writes();
   endtask

   // Mostly walls built through a point on the ray, plus near misses and noise.
   function automatic nrsh_pkg::req_type random_wall(input bit last);
      nrsh_pkg::req_type w;
      longint px, py, ddx, ddy;
      int mode;
      mode = $urandom_range(99);
      px = longint'(org_x) +
           (((longint'(ray_ex) - longint'(org_x)) * longint'($urandom_range(256))) >>> 8);
      py = longint'(org_y) +
           (((longint'(ray_ey) - longint'(org_y)) * longint'($urandom_range(256))) >>> 8);
      ddx = longint'($urandom_range(32'h0020_0000)) - 64'h0010_0000;
      ddy = longint'($urandom_range(32'h0020_0000)) - 64'h0010_0000;
      if (mode < 75) begin
         w.seg_start_x = COORD_W'(px + ddx);
         w.seg_start_y = COORD_W'(py + ddy);
         w.seg_end_x = COORD_W'(px - ddx);
         w.seg_end_y = COORD_W'(py - ddy);
         if (mode < 10) begin
            w.seg_start_x = COORD_W'(px);
            w.seg_start_y = COORD_W'(py);
         end
      end else if (mode < 90) begin
         w.seg_start_x = COORD_W'(px + ddx);
         w.seg_start_y = COORD_W'(py + ddy);
         w.seg_end_x = COORD_W'(px + ddy);
         w.seg_end_y = COORD_W'(py - ddx);
      end else begin
         w.seg_start_x = $urandom;
         w.seg_start_y = $urandom;
         w.seg_end_x = $urandom;
         w.seg_end_y = $urandom;
      end
      w.last_segment = last;
      return w;
   endfunction

   function automatic stim_row_type wall_row(input int ax, ay, bx, by, input bit last);
      stim_row_type row;
      row = '{kind: ROW_WALL, wall: '0, idx: '0, value: '0, typed: 0, want: '0};
      row.wall = '{fx(ax), fx(ay), fx(bx), fx(by), last};
      return row;
   endfunction

   function automatic stim_row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [COORD_W-1:0] value);
      stim_row_type row;
      row = '{kind: ROW_REG, wall: '0, idx: idx, value: value, typed: 0, want: '0};
      return row;
   endfunction

   initial begin
      stim_row_type plan[$];
      stim_row_type row;
      nrsh_pkg::rsp_type none;
      int words;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      org_x = '0; org_y = '0; ray_ex = '0; ray_ey = '0;
      cap = nrsh_pkg::CAP_RESET;
      clear_scene();
      none = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. A zero-length ray after reset can hit nothing.
      row = wall_row(1, -1, 1, 1, 1);
      row.typed = 1; row.want = none;
      plan.push_back(row);
      row = wall_row(0, 0, 0, 0, 1);
      row.wall = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1};
      row.typed = 1; row.want = none;
      plan.push_back(row);
      plan.push_back(reg_row(nrsh_pkg::CSR_RAY_END_X, fx(10)));
      row = wall_row(5, -1, 5, 1, 1);
      row.typed = 1; row.want = '{16'd1, 1'b1, fx(5), 32'd0};
      plan.push_back(row);
      plan.push_back(wall_row(0, 1, 10, 1, 0));     // parallel
      plan.push_back(wall_row(10, -1, 10, 1, 0));   // hit at the ray end
      plan.push_back(wall_row(0, 0, 0, 5, 0));      // touches the origin
      plan.push_back(wall_row(3, -1, 3, 1, 0));     // tie at x=3, first wins
      plan.push_back(wall_row(2, -1, 4, 1, 0));
      plan.push_back(wall_row(20, -1, 20, 1, 1));   // miss past the ray end
      plan.push_back(wall_row(7, -1, 7, 1, 0));
      plan.push_back(reg_row(nrsh_pkg::CSR_DISTANCE_CAP, fx(2)));   // hit kept: bound holds
      plan.push_back(wall_row(8, -1, 8, 1, 1));
      plan.push_back(wall_row(3, -1, 3, 1, 1));     // beyond the new cap
      plan.push_back(wall_row(1, -1, 1, 1, 0));
      plan.push_back(reg_row(nrsh_pkg::CSR_RAY_END_Y, fx(10)));     // ray change mid-scene
      plan.push_back(reg_row(CSR_UNMAPPED, 32'hFFFF_FFFF));
      plan.push_back(wall_row(0, 4, 4, 0, 1));
      plan.push_back(reg_row(nrsh_pkg::CSR_DISTANCE_CAP, 32'd0));
      plan.push_back(wall_row(0, 4, 4, 0, 1));
      plan.push_back(reg_row(nrsh_pkg::CSR_DISTANCE_CAP, 32'h7FFF_FFFF));
      plan.push_back(reg_row(nrsh_pkg::CSR_ORIGIN_X, 32'h8000_0000));
      plan.push_back(reg_row(nrsh_pkg::CSR_ORIGIN_Y, 32'h8000_0000));
      plan.push_back(reg_row(nrsh_pkg::CSR_RAY_END_X, 32'h7FFF_FFFF));
      plan.push_back(reg_row(nrsh_pkg::CSR_RAY_END_Y, 32'h7FFF_FFFF));
      row = wall_row(0, 0, 0, 0, 1);
      row.wall = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1};
      plan.push_back(row);

      tx_idle_pct = 11;
      rx_idle_pct = 70;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REG) begin
            stop_words();
            wait_drained();
            write_reg(plan[i].idx, plan[i].value);
            end_writes();
         end else begin
            send_wall(plan[i].wall, plan[i].typed, plan[i].want);
         end
      end

      // Random scenes in three idle profiles.
      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 70 : 0;
         rx_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 11 : 0;
         words = 0;
         for (int scene = 0; words < PHASE_WORDS; scene++) begin
            int len;
            if (scene % 25 == 0) load_ray();
            // hold the receiver off while walls keep coming, so the block backs up
            if (phase == 2 && scene == 1) hold_left = HOLD_CYCLES;
            len = ($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int k = 1; k <= len; k++) begin
               send_wall(random_wall(k == len), 0, none);
               words++;
            end
         end
      end

      stop_words();
      wait_drained();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
